/* rtl/core/bpfa_pkg.sv */
// Shared constants, types and a helper function of the bitmap page frame allocator.
package bpfa_pkg;

    localparam int NUM_PAGES  = 65536;
    localparam int MAP_BYTES  = NUM_PAGES / 8;
    localparam int BYTE_W     = $clog2(MAP_BYTES);
    localparam int CFG_W      = 14;
    localparam int ADDR_W     = 28;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int COUNT_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8192);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_PAGE = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic set_fail;
        logic set_oob;
        logic scan_next;
        logic alloc_commit;
        logic free_commit;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic used_zero;
        logic free_oob;
        logic scan_hit;
        logic scan_last;
        logic out_full;
    } stat_t;

    // Index of the lowest set bit of a byte; 7 when only bit 7 or no bit is set.
    function automatic logic [2:0] lowest_bit(input logic [7:0] b);
        logic [2:0] j;
        logic       seen;
        j    = 3'd7;
        seen = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!seen && b[k]) begin
                j    = 3'(k);
                seen = 1'b1;
            end
        end
        return j;
    endfunction

endpackage

/* rtl/core/bpfa_ctrl.sv */
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            op,
    input  bpfa_pkg::stat_t stat,
    output logic            s_tready,
    output bpfa_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_ALLOC_RD  = 7'b0000100,
        ST_ALLOC_CHK = 7'b0001000,
        ST_FREE_RD   = 7'b0010000,
        ST_FREE_WR   = 7'b0100000,
        ST_RESP      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (op == bpfa_pkg::OP_FREE) begin
                        if (stat.free_oob) begin
                            cmd.set_oob = 1'b1;
                            state_next  = ST_RESP;
                        end else begin
                            state_next = ST_FREE_RD;
                        end
                    end else if (stat.used_zero) begin
                        cmd.set_fail = 1'b1;
                        state_next   = ST_RESP;
                    end else begin
                        state_next = ST_ALLOC_RD;
                    end
                end
            end
            ST_ALLOC_RD: begin
                state_next = ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK: begin
                if (stat.scan_hit) begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = ST_RESP;
                end else if (stat.scan_last) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_ALLOC_RD;
                end
            end
            ST_FREE_RD: begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                cmd.free_commit = 1'b1;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!stat.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/bpfa_datapath.sv */
// Datapath of the bitmap page frame allocator: bitmap memory, scan pointer and counters.
module bpfa_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bpfa_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              op,
    input  logic [bpfa_pkg::ADDR_W-1:0]       page_address,
    input  logic                              m_tready,
    input  bpfa_pkg::cmd_t                    cmd,
    output bpfa_pkg::stat_t                   stat,
    output logic                              m_tvalid,
    output logic [bpfa_pkg::STATUS_W-1:0]     m_status,
    output logic [bpfa_pkg::ADDR_W-1:0]       m_addr,
    output logic [bpfa_pkg::COUNT_W-1:0]      m_count
);

    localparam int BW = bpfa_pkg::BYTE_W;
    localparam int CW = bpfa_pkg::CFG_W;

    logic [7:0]                     mem [bpfa_pkg::MAP_BYTES];
    logic [7:0]                     rd_data_reg;
    logic [BW:0]                    clr_cnt_reg;
    logic [CW-1:0]                  cfg_reg;
    logic [BW-1:0]                  ptr_reg;
    logic                           pass_reg;
    logic [BW-1:0]                  last_reg;
    logic [2:0]                     bit_reg;
    logic [bpfa_pkg::COUNT_W-1:0]   free_pages_reg;
    bpfa_pkg::status_t              res_status_reg;
    logic [bpfa_pkg::ADDR_W-1:0]    res_addr_reg;
    logic                           m_valid_reg;
    logic [bpfa_pkg::STATUS_W-1:0]  m_status_reg;
    logic [bpfa_pkg::ADDR_W-1:0]    m_addr_reg;
    logic [bpfa_pkg::COUNT_W-1:0]   m_count_reg;

    logic [CW-1:0]                  used;
    logic [CW-1:0]                  last_ext;
    logic [CW-1:0]                  wrap_end;
    logic [CW-1:0]                  ptr_inc;
    logic [bpfa_pkg::PAGE_W-1:0]    page;
    logic [2:0]                     low_bit;
    logic                           mem_we;
    logic [BW-1:0]                  mem_waddr;
    logic [7:0]                     mem_wdata;

    // The effective byte count saturates at the map size.
    assign used     = (cfg_reg > CW'(bpfa_pkg::MAP_BYTES)) ? CW'(bpfa_pkg::MAP_BYTES) : cfg_reg;
    assign last_ext = CW'(last_reg);
    assign wrap_end = (last_ext < used) ? last_ext : used;
    assign ptr_inc  = CW'(ptr_reg) + CW'(1);
    assign page     = page_address[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
    assign low_bit  = bpfa_pkg::lowest_bit(rd_data_reg);

    assign stat.clear_done = clr_cnt_reg[BW];
    assign stat.used_zero  = (used == '0);
    assign stat.free_oob   = ({1'b0, page} >= {used, 3'b000});
    assign stat.scan_hit   = (rd_data_reg != 8'd0);
    assign stat.scan_last  = pass_reg ? (ptr_inc >= wrap_end)
                                      : ((ptr_inc == used) && (last_reg == '0));
    assign stat.out_full   = m_valid_reg && !m_tready;

    // Memory write port: clearing pass, allocate clear-bit and free set-bit.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = rd_data_reg;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[BW-1:0];
            mem_wdata = 8'd0;
        end else if (cmd.alloc_commit) begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_reg & ~(8'd1 << low_bit);
        end else if (cmd.free_commit) begin
            mem_we    = !rd_data_reg[bit_reg];
            mem_wdata = rd_data_reg | (8'd1 << bit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            cfg_reg        <= bpfa_pkg::CFG_RESET;
            last_reg       <= '0;
            free_pages_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + (BW+1)'(1);
            end
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.alloc_commit) begin
                last_reg <= ptr_reg;
                if (free_pages_reg != '0) begin
                    free_pages_reg <= free_pages_reg - bpfa_pkg::COUNT_W'(1);
                end
            end
            if (cmd.free_commit && !rd_data_reg[bit_reg]) begin
                free_pages_reg <= free_pages_reg + bpfa_pkg::COUNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // An early failure is flagged in the same cycle the request is taken.
        if (cmd.set_fail) begin
            res_status_reg <= bpfa_pkg::STATUS_NO_PAGE;
        end else if (cmd.set_oob) begin
            res_status_reg <= bpfa_pkg::STATUS_RANGE;
        end else if (cmd.accept) begin
            res_status_reg <= bpfa_pkg::STATUS_OK;
        end
        if (cmd.accept) begin
            res_addr_reg <= '0;
            if (op == bpfa_pkg::OP_FREE) begin
                ptr_reg <= BW'(page >> 3);
                bit_reg <= page[2:0];
            end else if (last_ext < used) begin
                ptr_reg  <= last_reg;
                pass_reg <= 1'b0;
            end else begin
                ptr_reg  <= '0;
                pass_reg <= 1'b1;
            end
        end
        if (cmd.scan_next) begin
            if (!pass_reg && (ptr_inc == used)) begin
                ptr_reg  <= '0;
                pass_reg <= 1'b1;
            end else begin
                ptr_reg <= ptr_inc[BW-1:0];
            end
        end
        if (cmd.alloc_commit) begin
            res_addr_reg <= bpfa_pkg::ADDR_W'({ptr_reg, low_bit,
                                               bpfa_pkg::PAGE_SHIFT'(0)});
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_count_reg  <= free_pages_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_addr   = m_addr_reg;
    assign m_count  = m_count_reg;

endmodule

/* rtl/core/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator.
//
// Each transaction on the slave stream is one request: s_tuser carries the
// operation (allocate or free) and s_tdata carries the byte address of the
// page to free. Each request yields exactly one transaction on the master
// stream: m_tuser carries the status, and m_tdata carries the allocated
// page address and the count of free pages after the request.
// The register bytes_in_use is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. It bounds both the search and the free range. A free
// passes through the read, write and response states before m_tvalid rises; a
// free out of range or an allocate with no byte in use goes straight to the
// response state. An allocate scans the bitmap memory with one read and one
// check per byte, from the byte of the last allocation. One request is worked
// on at a time; s_tready is high only when idle. After reset the block runs a
// clearing pass over the 8192-byte bitmap, one byte a cycle, with s_tready low;
// no page is free until software frees pages. A result waits in the output
// register while the receiver stalls; the next request may be accepted and
// worked on meanwhile, and its result waits until the output register drains.
module bitmap_page_frame_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bpfa_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: page_address[27:0], zero padding.
    input  logic [bpfa_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: operation.
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: alloc_address[27:0], pages_available[44:28], zero padding.
    output logic [bpfa_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser fields from bit 0: status.
    output logic [bpfa_pkg::STATUS_W-1:0]     m_tuser
);

    bpfa_pkg::cmd_t                   cmd;
    bpfa_pkg::stat_t                  stat;
    logic [bpfa_pkg::ADDR_W-1:0]      m_addr;
    logic [bpfa_pkg::COUNT_W-1:0]     m_count;

    // The controller sequences each request through read, check and write steps.
    bpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // The datapath owns the bitmap memory, the scan pointer and the counters.
    bpfa_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op           (s_tuser),
        .page_address (s_tdata[bpfa_pkg::ADDR_W-1:0]),
        .m_tready     (m_tready),
        .cmd          (cmd),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .m_status     (m_tuser),
        .m_addr       (m_addr),
        .m_count      (m_count)
    );

    // Pack the result fields, lowest field first, padded with zeros.
    assign m_tdata = {{(bpfa_pkg::OUT_DATA_W - bpfa_pkg::COUNT_W - bpfa_pkg::ADDR_W){1'b0}},
                      m_count, m_addr};

endmodule

/* rtl/core/bpfa_checker.sv */
// Port-level assertion checker of the bitmap page frame allocator, with its bind.
module bpfa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bpfa_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [bpfa_pkg::STATUS_W-1:0]     m_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Failed requests never report a page address.
    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != bpfa_pkg::STATUS_OK) |-> (m_tdata[27:0] == 28'd0))
        else $error("failed request carries an address");

    // The free-page count never exceeds the number of pages, and the status is never beyond the range code.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[44:28] <= 17'd65536) && (m_tuser <= bpfa_pkg::STATUS_RANGE))
        else $error("bad count or status");

    // Reset leaves no result pending and no request taken.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready right after reset");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
